@@ src/mgp_pkg.sv @@
// ============================================================================
// mgp_pkg
// shared types, register codes and defaults for the pressure projection block
// ============================================================================
`default_nettype none

package mgp_pkg;

    localparam int DEF_MAX_GRID_X = 64;
    localparam int DEF_MAX_GRID_Y = 64;
    localparam int DEF_MAX_GRID_Z = 64;

    localparam int GRID_W  = 7;
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;

    localparam logic [GRID_W-1:0] RST_GRID  = 7'd64;
    localparam logic [DATA_W-1:0] RST_SCALE = 32'h0100_0000;

    localparam logic [1:0] CELL_AIR   = 2'd0;
    localparam logic [1:0] CELL_SOLID = 2'd2;

    typedef struct packed {
        logic               solid;
        logic [DATA_W-1:0]  pressure;
    } ring_entry_t;

    typedef struct packed {
        logic x_nz;
        logic y_nz;
        logic z_nz;
        logic last;
    } pos_flags_t;

endpackage

`default_nettype wire

@@ src/mgp_plane_ring.sv @@
// ============================================================================
// mgp_plane_ring
// one y-z plane of effective pressure and solid marks, one write two reads
// ============================================================================
`default_nettype none

module mgp_plane_ring #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire mgp_pkg::ring_entry_t wr_data,
    input  wire logic [AW-1:0]        rd_addr_a,
    input  wire logic [AW-1:0]        rd_addr_b,
    output mgp_pkg::ring_entry_t      rd_data_a,
    output mgp_pkg::ring_entry_t      rd_data_b
);

    mgp_pkg::ring_entry_t mem [DEPTH];
    mgp_pkg::ring_entry_t rd_a_reg;
    mgp_pkg::ring_entry_t rd_b_reg;

    // read returns the entry as it stood before this beat's write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem[wr_addr] <= wr_data;
            rd_a_reg     <= mem[rd_addr_a];
            rd_b_reg     <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

@@ src/mgp_position.sv @@
// ============================================================================
// mgp_position
// raster position counters, edge flags and ring addresses
// ============================================================================
`default_nettype none

module mgp_position #(
    parameter int MAX_GRID_X = mgp_pkg::DEF_MAX_GRID_X,
    parameter int MAX_GRID_Y = mgp_pkg::DEF_MAX_GRID_Y,
    parameter int MAX_GRID_Z = mgp_pkg::DEF_MAX_GRID_Z,
    parameter int AW         = $clog2(MAX_GRID_Y * MAX_GRID_Z)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic [mgp_pkg::GRID_W-1:0]  grid_x,
    input  wire logic [mgp_pkg::GRID_W-1:0]  grid_y,
    input  wire logic [mgp_pkg::GRID_W-1:0]  grid_z,
    output mgp_pkg::pos_flags_t              flags,
    output logic [AW-1:0]                    here_addr,
    output logic [AW-1:0]                    up_y_addr
);

    localparam int XW = $clog2(MAX_GRID_X);
    localparam int YW = $clog2(MAX_GRID_Y);
    localparam int ZW = $clog2(MAX_GRID_Z);
    localparam int SXW = ($clog2(MAX_GRID_X + 1) > mgp_pkg::GRID_W) ?
                         $clog2(MAX_GRID_X + 1) : mgp_pkg::GRID_W;
    localparam int SYW = ($clog2(MAX_GRID_Y + 1) > mgp_pkg::GRID_W) ?
                         $clog2(MAX_GRID_Y + 1) : mgp_pkg::GRID_W;
    localparam int SZW = ($clog2(MAX_GRID_Z + 1) > mgp_pkg::GRID_W) ?
                         $clog2(MAX_GRID_Z + 1) : mgp_pkg::GRID_W;

    logic [XW-1:0] pos_x_reg, pos_x_next;
    logic [YW-1:0] pos_y_reg, pos_y_next;
    logic [ZW-1:0] pos_z_reg, pos_z_next;

    logic [SXW-1:0] size_x, gx_ext, x_inc;
    logic [SYW-1:0] size_y, gy_ext, y_inc;
    logic [SZW-1:0] size_z, gz_ext, z_inc;

    // sizes clamped to one up to the maximum
    always_comb
    begin
        gx_ext = SXW'(grid_x);
        gy_ext = SYW'(grid_y);
        gz_ext = SZW'(grid_z);
        priority if (gx_ext == '0)                   size_x = SXW'(1);
        else if (gx_ext > SXW'(MAX_GRID_X))          size_x = SXW'(MAX_GRID_X);
        else                                         size_x = gx_ext;
        priority if (gy_ext == '0)                   size_y = SYW'(1);
        else if (gy_ext > SYW'(MAX_GRID_Y))          size_y = SYW'(MAX_GRID_Y);
        else                                         size_y = gy_ext;
        priority if (gz_ext == '0)                   size_z = SZW'(1);
        else if (gz_ext > SZW'(MAX_GRID_Z))          size_z = SZW'(MAX_GRID_Z);
        else                                         size_z = gz_ext;
    end

    always_comb
    begin
        x_inc = SXW'(pos_x_reg) + SXW'(1);
        y_inc = SYW'(pos_y_reg) + SYW'(1);
        z_inc = SZW'(pos_z_reg) + SZW'(1);

        flags.x_nz = (pos_x_reg != '0);
        flags.y_nz = (pos_y_reg != '0);
        flags.z_nz = (pos_z_reg != '0);
        flags.last = (x_inc == size_x) && (y_inc == size_y) && (z_inc == size_z);

        here_addr = AW'(pos_y_reg) * AW'(MAX_GRID_Z) + AW'(pos_z_reg);
        up_y_addr = here_addr - AW'(MAX_GRID_Z);

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (advance)
        begin
            priority if (z_inc < size_z)
            begin
                pos_z_next = ZW'(z_inc);
            end
            else if (y_inc < size_y)
            begin
                pos_z_next = '0;
                pos_y_next = YW'(y_inc);
            end
            else
            begin
                pos_z_next = '0;
                pos_y_next = '0;
                pos_x_next = (x_inc < size_x) ? XW'(x_inc) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

endmodule

`default_nettype wire

@@ src/mgp_face_proj.sv @@
// ============================================================================
// mgp_face_proj
// one face: velocity minus rounded scaled pressure difference, saturated
// ============================================================================
`default_nettype none

module mgp_face_proj (
    input  wire logic                              keep,
    input  wire logic signed [mgp_pkg::DATA_W-1:0] vel,
    input  wire logic signed [mgp_pkg::DATA_W-1:0] p_cell,
    input  wire logic signed [mgp_pkg::DATA_W-1:0] p_neigh,
    input  wire logic        [mgp_pkg::DATA_W-1:0] scale,
    output logic signed      [mgp_pkg::DATA_W-1:0] vel_out
);

    localparam int DW = mgp_pkg::DATA_W;
    localparam int PW = 2 * DW + 1;
    localparam int QW = PW - 24;
    localparam int RW = QW + 2;

    logic signed [DW:0]   diff;
    logic        [DW:0]   mag;
    logic        [PW-1:0] prod;
    logic        [PW-1:0] rnd;
    logic        [QW-1:0] q;
    logic signed [RW-1:0] term;
    logic signed [RW-1:0] res;
    logic                 fits;

    always_comb
    begin
        diff = {p_cell[DW-1], p_cell} - {p_neigh[DW-1], p_neigh};
        mag  = diff[DW] ? (~diff + (DW+1)'(1)) : diff;
        prod = PW'(mag) * PW'(scale);
        // round to nearest, ties away from zero on the magnitude
        rnd  = prod + (PW'(1) << 23);
        q    = rnd[PW-1:24];
        term = diff[DW] ? -$signed({2'b00, q}) : $signed({2'b00, q});
        res  = RW'(vel) - term;
        fits = (res[RW-1:DW-1] == '0) || (res[RW-1:DW-1] == '1);
        priority if (!keep)
            vel_out = '0;
        else if (fits)
            vel_out = res[DW-1:0];
        else if (res[RW-1])
            vel_out = {1'b1, {(DW-1){1'b0}}};
        else
            vel_out = {1'b0, {(DW-1){1'b1}}};
    end

endmodule

`default_nettype wire

@@ src/mac_grid_pressure_projection_unit.sv @@
// ============================================================================
// mac_grid_pressure_projection_unit
// pressure gradient projection of low face velocities on a staggered grid
// ============================================================================
//
//  channel   side    handshake                 beat contents
//  s_axis    in      s_axis_tvalid/tready      pressure, vel_x/y/z, type in tuser
//  m_axis    out     m_axis_tvalid/tready      vel_x/y/z out, last cell in tlast
//  cfg       in      cfg_valid/cfg_ready       register index and write data
//
//  one beat per cycle in and out while the output is not stalled
//  the first stage reads the plane ring (one write, two reads) and registers the cell
//  the output stage does the three face multiplies into the output register
//  the ring needs no clearing pass: every neighbor read follows its write
//  reset clears positions and valids and sets the config registers to defaults
//  a stalled output holds; input keeps flowing while the output register is free
//
`default_nettype none

module mac_grid_pressure_projection_unit #(
    parameter int MAX_GRID_X = mgp_pkg::DEF_MAX_GRID_X,
    parameter int MAX_GRID_Y = mgp_pkg::DEF_MAX_GRID_Y,
    parameter int MAX_GRID_Z = mgp_pkg::DEF_MAX_GRID_Z
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // pressure, vel_x_in, vel_y_in, vel_z_in
    input  wire logic [4*mgp_pkg::DATA_W-1:0]   s_axis_tdata,
    // cell_type
    input  wire logic [1:0]                     s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // vel_x_out, vel_y_out, vel_z_out
    output logic [3*mgp_pkg::DATA_W-1:0]        m_axis_tdata,
    output logic                                m_axis_tlast,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mgp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mgp_pkg::DATA_W-1:0]     cfg_data
);

    localparam int DW    = mgp_pkg::DATA_W;
    localparam int DEPTH = MAX_GRID_Y * MAX_GRID_Z;
    localparam int AW    = $clog2(DEPTH);

    logic [mgp_pkg::GRID_W-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
    logic [DW-1:0]              scale_reg;

    logic accept;
    logic s1_adv;
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;

    mgp_pkg::pos_flags_t  pos_flags;
    logic [AW-1:0]        here_addr, up_y_addr;
    mgp_pkg::ring_entry_t cur_entry;
    mgp_pkg::ring_entry_t nb_x, nb_y;

    mgp_pkg::ring_entry_t prev_entry_reg;
    mgp_pkg::ring_entry_t s1_cur_reg;
    mgp_pkg::ring_entry_t s1_nb_z_reg;
    mgp_pkg::pos_flags_t  s1_flags_reg;
    logic [DW-1:0]        s1_vx_reg, s1_vy_reg, s1_vz_reg;

    logic [DW-1:0] proj_x, proj_y, proj_z;
    logic [DW-1:0] out_vx_reg, out_vy_reg, out_vz_reg;
    logic          out_last_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg <= mgp_pkg::RST_GRID;
            grid_y_reg <= mgp_pkg::RST_GRID;
            grid_z_reg <= mgp_pkg::RST_GRID;
            scale_reg  <= mgp_pkg::RST_SCALE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mgp_pkg::CFG_GRID_X: grid_x_reg <= cfg_data[mgp_pkg::GRID_W-1:0];
                mgp_pkg::CFG_GRID_Y: grid_y_reg <= cfg_data[mgp_pkg::GRID_W-1:0];
                mgp_pkg::CFG_GRID_Z: grid_z_reg <= cfg_data[mgp_pkg::GRID_W-1:0];
                mgp_pkg::CFG_SCALE:  scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    always_comb
    begin
        s1_adv         = s1_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready  = !s1_valid_reg || s1_adv;
        accept         = s_axis_tvalid && s_axis_tready;
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input decode: air counts as zero pressure
    always_comb
    begin
        cur_entry.solid    = (s_axis_tuser == mgp_pkg::CELL_SOLID);
        cur_entry.pressure = (s_axis_tuser == mgp_pkg::CELL_AIR) ? '0 :
                             s_axis_tdata[DW-1:0];
    end

    mgp_position #(
        .MAX_GRID_X (MAX_GRID_X),
        .MAX_GRID_Y (MAX_GRID_Y),
        .MAX_GRID_Z (MAX_GRID_Z),
        .AW         (AW)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .grid_x    (grid_x_reg),
        .grid_y    (grid_y_reg),
        .grid_z    (grid_z_reg),
        .flags     (pos_flags),
        .here_addr (here_addr),
        .up_y_addr (up_y_addr)
    );

    mgp_plane_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk       (clk),
        .en        (accept),
        .wr_addr   (here_addr),
        .wr_data   (cur_entry),
        .rd_addr_a (here_addr),
        .rd_addr_b (up_y_addr),
        .rd_data_a (nb_x),
        .rd_data_b (nb_y)
    );

    // first stage; the z neighbor is the previous cell
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_entry_reg <= cur_entry;
            s1_nb_z_reg    <= prev_entry_reg;
            s1_cur_reg     <= cur_entry;
            s1_flags_reg   <= pos_flags;
            s1_vx_reg      <= s_axis_tdata[2*DW-1:DW];
            s1_vy_reg      <= s_axis_tdata[3*DW-1:2*DW];
            s1_vz_reg      <= s_axis_tdata[4*DW-1:3*DW];
        end
    end

    mgp_face_proj u_face_x (
        .keep    (s1_flags_reg.x_nz && !s1_cur_reg.solid && !nb_x.solid),
        .vel     (s1_vx_reg),
        .p_cell  (s1_cur_reg.pressure),
        .p_neigh (nb_x.pressure),
        .scale   (scale_reg),
        .vel_out (proj_x)
    );

    mgp_face_proj u_face_y (
        .keep    (s1_flags_reg.y_nz && !s1_cur_reg.solid && !nb_y.solid),
        .vel     (s1_vy_reg),
        .p_cell  (s1_cur_reg.pressure),
        .p_neigh (nb_y.pressure),
        .scale   (scale_reg),
        .vel_out (proj_y)
    );

    mgp_face_proj u_face_z (
        .keep    (s1_flags_reg.z_nz && !s1_cur_reg.solid && !s1_nb_z_reg.solid),
        .vel     (s1_vz_reg),
        .p_cell  (s1_cur_reg.pressure),
        .p_neigh (s1_nb_z_reg.pressure),
        .scale   (scale_reg),
        .vel_out (proj_z)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_vx_reg   <= proj_x;
            out_vy_reg   <= proj_y;
            out_vz_reg   <= proj_z;
            out_last_reg <= s1_flags_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_vz_reg, out_vy_reg, out_vx_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ src/mgp_checker.sv @@
// ============================================================================
// mgp_checker
// port-level checks on the pressure projection block
// ============================================================================
`default_nettype none

module mgp_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [3*mgp_pkg::DATA_W-1:0]   m_axis_tdata,
    input  wire logic                           m_axis_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // input only backs up when the output register is full and stalled
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room downstream");

    // a fresh output beat comes from an earlier accepted input beat, through the first stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output beat without matching input beat");

endmodule

bind mac_grid_pressure_projection_unit mgp_checker u_mgp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
